// ----- hdl/ptp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the plane-to-pixel point mapper
// no dependencies

package ptp_pkg;

    localparam int PIXEL_BOUND = 32767;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;

    typedef enum logic [CFG_IW-1:0] {
        REG_MODE        = 3'd0,
        REG_MATRIX      = 3'd1,
        REG_MOBIUS      = 3'd2,
        REG_OFFSET_X    = 3'd3,
        REG_OFFSET_Y    = 3'd4,
        REG_TRANSLATION = 3'd5,
        REG_SCALE_X     = 3'd6,
        REG_SCALE_Y     = 3'd7
    } t_reg_idx;

    // transform modes, code 3 behaves as the matrix
    localparam logic [1:0] MODE_IDENT  = 2'd0;
    localparam logic [1:0] MODE_MATRIX = 2'd1;
    localparam logic [1:0] MODE_MOBIUS = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // divider widths
    localparam int NUM_MW     = 62;
    localparam int DEN_W      = 57;
    localparam int DIV_QW     = 31;
    localparam int DIV_CW     = DEN_W + DIV_QW;
    localparam int DIV_STAGES = DIV_QW + 2;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               last;
        logic               dz;
    } t_side;

    typedef struct packed {
        logic [NUM_MW-1:0] mag_re;
        logic [NUM_MW-1:0] mag_im;
        logic              neg_re;
        logic              neg_im;
        logic [DEN_W-1:0]  den;
        t_side             side;
    } t_div_in;

endpackage

// ----- hdl/ptp_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces of the point mapper: points, pixels, configuration
// depends on ptp_pkg

interface ptp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface ptp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic signed [31:0] shifted_x;
    logic signed [31:0] shifted_y;
    logic               denominator_zero;
    logic               last_out;

    modport source (output valid, pixel_x, pixel_y, shifted_x, shifted_y,
                    denominator_zero, last_out, input ready);
    modport sink (input valid, pixel_x, pixel_y, shifted_x, shifted_y,
                  denominator_zero, last_out, output ready);
endinterface

interface ptp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ptp_pkg::CFG_IW-1:0]    index;
    logic [ptp_pkg::CFG_DW-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/plane_transform_to_pixel.sv -----
`timescale 1ns / 1ps
// top level of the plane-to-pixel point mapper: transform, viewport offset, scale, clamp
// depends on ptp_pkg, ptp_if and ptp_div

// Maps each Q16.16 point word to pixel coordinates. The mode register picks
// pass-through, a 2x2 Q4.12 matrix, or the Mobius map (z+w)/(conj(w)z+1)
// followed by a rotation. The result is offset, scaled, rounded half to even
// and clamped to +-PIXEL_BOUND; the transformed point plus translation also
// comes out, saturated. A zero Mobius denominator gives saturated results and
// raises denominator_zero. The pipeline takes one point word per clock unless
// backpressure holds it, and passes each one through 8 front stages (Mobius
// numerator/denominator and normalization), 33 divider stages (one quotient bit
// per stage over 31 bits, plus setup and rounding) and 6 back stages (matrix or
// rotation, offset, scale, clamp). All modes take the same path, so results
// leave in order. Backpressure stalls only the stages that hold data, so
// bubbles close up. Configuration writes are taken at any time but must only
// be made while no point is in flight.

module plane_transform_to_pixel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptp_cfg_if.sink    i_cfg,
    ptp_in_if.sink     i_pt,
    ptp_out_if.source  o_px
);
    import ptp_pkg::*;

    localparam int NF = 8;
    localparam int NB = 6;
    localparam logic signed [48:0] Q_ONE = 49'sd268435456;
    localparam logic signed [34:0] PB    = 35'(PIXEL_BOUND);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         r_mode;
    logic [63:0]        r_mat;
    logic [63:0]        r_mob;
    logic signed [31:0] r_offx;
    logic signed [31:0] r_offy;
    logic [63:0]        r_trans;
    logic signed [31:0] r_scx;
    logic signed [31:0] r_scy;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDENT;
            r_mat   <= '0;
            r_mob   <= '0;
            r_offx  <= '0;
            r_offy  <= '0;
            r_trans <= '0;
            r_scx   <= 32'sd65536;
            r_scy   <= 32'sd65536;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_MODE:        r_mode  <= i_cfg.data[1:0];
                REG_MATRIX:      r_mat   <= i_cfg.data;
                REG_MOBIUS:      r_mob   <= i_cfg.data;
                REG_OFFSET_X:    r_offx  <= signed'(i_cfg.data[31:0]);
                REG_OFFSET_Y:    r_offy  <= signed'(i_cfg.data[31:0]);
                REG_TRANSLATION: r_trans <= i_cfg.data;
                REG_SCALE_X:     r_scx   <= signed'(i_cfg.data[31:0]);
                REG_SCALE_Y:     r_scy   <= signed'(i_cfg.data[31:0]);
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic signed [15:0] w_a, w_b, w_c, w_s;
    logic signed [15:0] w_m00, w_m01, w_m10, w_m11;
    logic signed [19:0] w_a16, w_b16;
    logic signed [31:0] w_tx, w_ty;

    assign w_a   = signed'(r_mob[15:0]);
    assign w_b   = signed'(r_mob[31:16]);
    assign w_c   = signed'(r_mob[47:32]);
    assign w_s   = signed'(r_mob[63:48]);
    assign w_m00 = signed'(r_mat[15:0]);
    assign w_m01 = signed'(r_mat[31:16]);
    assign w_m10 = signed'(r_mat[47:32]);
    assign w_m11 = signed'(r_mat[63:48]);
    assign w_a16 = {w_a, 4'b0000};
    assign w_b16 = {w_b, 4'b0000};
    assign w_tx  = signed'(r_trans[31:0]);
    assign w_ty  = signed'(r_trans[63:32]);

    // ------------------------------------------------------------------
    // stall chain: a stage loads when it is empty or the next one moves
    // ------------------------------------------------------------------
    logic [NF-1:0] r_fv, w_frdy, w_fvin;
    logic [NB-1:0] r_bv, w_brdy, w_bvin;
    logic          w_div_irdy, w_div_ovld;

    always_comb begin
        w_brdy[NB-1] = !r_bv[NB-1] || o_px.ready;
        for (int k = NB - 2; k >= 0; k--) begin
            w_brdy[k] = !r_bv[k] || w_brdy[k+1];
        end
        w_frdy[NF-1] = !r_fv[NF-1] || w_div_irdy;
        for (int k = NF - 2; k >= 0; k--) begin
            w_frdy[k] = !r_fv[k] || w_frdy[k+1];
        end
    end

    assign w_fvin     = {r_fv[NF-2:0], i_pt.valid};
    assign w_bvin     = {r_bv[NB-2:0], w_div_ovld};
    assign i_pt.ready = w_frdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_bv <= '0;
        end else begin
            for (int k = 0; k < NF; k++) begin
                if (w_frdy[k]) begin
                    r_fv[k] <= w_fvin[k];
                end
            end
            for (int k = 0; k < NB; k++) begin
                if (w_brdy[k]) begin
                    r_bv[k] <= w_bvin[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // front: Mobius numerator P = z + w and denominator Q = conj(w)z + 1
    // ------------------------------------------------------------------
    logic signed [47:0] r_f1_apx, r_f1_bpy, r_f1_apy, r_f1_bpx;
    logic signed [32:0] r_f1_pre, r_f1_pim;
    t_side              r_f1_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[0]) begin
            r_f1_apx       <= w_a * i_pt.point_x;
            r_f1_bpy       <= w_b * i_pt.point_y;
            r_f1_apy       <= w_a * i_pt.point_y;
            r_f1_bpx       <= w_b * i_pt.point_x;
            r_f1_pre       <= 33'(i_pt.point_x) + 33'(w_a16);
            r_f1_pim       <= 33'(i_pt.point_y) + 33'(w_b16);
            r_f1_side.px   <= i_pt.point_x;
            r_f1_side.py   <= i_pt.point_y;
            r_f1_side.last <= i_pt.last_point;
            r_f1_side.dz   <= 1'b0;
        end
    end

    logic signed [48:0] r_f2_qre, r_f2_qim;
    logic signed [32:0] r_f2_pre, r_f2_pim;
    t_side              r_f2_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[1]) begin
            r_f2_qre  <= 49'(r_f1_apx) + 49'(r_f1_bpy) + Q_ONE;
            r_f2_qim  <= 49'(r_f1_apy) - 49'(r_f1_bpx);
            r_f2_pre  <= r_f1_pre;
            r_f2_pim  <= r_f1_pim;
            r_f2_side <= r_f1_side;
        end
    end

    // magnitudes and zero-denominator test
    logic [47:0]        r_f3_mr, r_f3_mi;
    logic               r_f3_nr, r_f3_ni;
    logic signed [32:0] r_f3_pre, r_f3_pim;
    t_side              r_f3_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[2]) begin
            r_f3_mr        <= 48'(r_f2_qre[48] ? -r_f2_qre : r_f2_qre);
            r_f3_mi        <= 48'(r_f2_qim[48] ? -r_f2_qim : r_f2_qim);
            r_f3_nr        <= r_f2_qre[48];
            r_f3_ni        <= r_f2_qim[48];
            r_f3_pre       <= r_f2_pre;
            r_f3_pim       <= r_f2_pim;
            r_f3_side.px   <= r_f2_side.px;
            r_f3_side.py   <= r_f2_side.py;
            r_f3_side.last <= r_f2_side.last;
            r_f3_side.dz   <= (r_f2_qre == '0) && (r_f2_qim == '0) && (r_mode == MODE_MOBIUS);
        end
    end

    // shift that brings both magnitudes below 2^28
    logic [47:0] w_or;
    logic [5:0]  w_hi;
    logic [4:0]  w_sh;

    always_comb begin
        w_or = r_f3_mr | r_f3_mi;
        w_hi = '0;
        for (int i = 0; i < 48; i++) begin
            if (w_or[i]) begin
                w_hi = 6'(i);
            end
        end
        w_sh = (w_hi >= 6'd28) ? 5'(w_hi - 6'd27) : 5'd0;
    end

    logic [4:0]         r_f4_sh;
    logic [47:0]        r_f4_mr, r_f4_mi;
    logic               r_f4_nr, r_f4_ni;
    logic signed [32:0] r_f4_pre, r_f4_pim;
    t_side              r_f4_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[3]) begin
            r_f4_sh   <= w_sh;
            r_f4_mr   <= r_f3_mr;
            r_f4_mi   <= r_f3_mi;
            r_f4_nr   <= r_f3_nr;
            r_f4_ni   <= r_f3_ni;
            r_f4_pre  <= r_f3_pre;
            r_f4_pim  <= r_f3_pim;
            r_f4_side <= r_f3_side;
        end
    end

    logic [47:0]        w_mrs, w_mis;
    logic signed [28:0] w_rre, w_rim;

    assign w_mrs = r_f4_mr >> r_f4_sh;
    assign w_mis = r_f4_mi >> r_f4_sh;
    assign w_rre = {1'b0, w_mrs[27:0]};
    assign w_rim = {1'b0, w_mis[27:0]};

    logic signed [28:0] r_f5_rre, r_f5_rim;
    logic signed [32:0] r_f5_pre, r_f5_pim;
    t_side              r_f5_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[4]) begin
            r_f5_rre  <= r_f4_nr ? -w_rre : w_rre;
            r_f5_rim  <= r_f4_ni ? -w_rim : w_rim;
            r_f5_pre  <= r_f4_pre;
            r_f5_pim  <= r_f4_pim;
            r_f5_side <= r_f4_side;
        end
    end

    // |Q'|^2 and P * conj(Q') partial products
    logic signed [57:0] r_f6_rr2, r_f6_ii2;
    logic signed [61:0] r_f6_pr, r_f6_pi, r_f6_qr, r_f6_qi;
    t_side              r_f6_side;

    always_ff @(posedge i_clk) begin
        if (w_frdy[5]) begin
            r_f6_rr2  <= r_f5_rre * r_f5_rre;
            r_f6_ii2  <= r_f5_rim * r_f5_rim;
            r_f6_pr   <= r_f5_pre * r_f5_rre;
            r_f6_pi   <= r_f5_pim * r_f5_rim;
            r_f6_qr   <= r_f5_pim * r_f5_rre;
            r_f6_qi   <= r_f5_pre * r_f5_rim;
            r_f6_side <= r_f5_side;
        end
    end

    logic signed [57:0] w_den;
    logic [DEN_W-1:0]   r_f7_d;
    logic signed [62:0] r_f7_nre, r_f7_nim;
    t_side              r_f7_side;

    assign w_den = r_f6_rr2 + r_f6_ii2;

    always_ff @(posedge i_clk) begin
        if (w_frdy[6]) begin
            r_f7_d    <= w_den[DEN_W-1:0];
            r_f7_nre  <= 63'(r_f6_pr) + 63'(r_f6_pi);
            r_f7_nim  <= 63'(r_f6_qr) - 63'(r_f6_qi);
            r_f7_side <= r_f6_side;
        end
    end

    t_div_in r_f8_din;

    always_ff @(posedge i_clk) begin
        if (w_frdy[7]) begin
            r_f8_din.mag_re <= NUM_MW'(r_f7_nre[62] ? -r_f7_nre : r_f7_nre);
            r_f8_din.mag_im <= NUM_MW'(r_f7_nim[62] ? -r_f7_nim : r_f7_nim);
            r_f8_din.neg_re <= r_f7_nre[62];
            r_f8_din.neg_im <= r_f7_nim[62];
            r_f8_din.den    <= r_f7_d;
            r_f8_din.side   <= r_f7_side;
        end
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic signed [31:0] w_xx, w_yy;
    t_side              w_dside;

    ptp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_fv[NF-1]),
        .o_rdy    (w_div_irdy),
        .i_din    (r_f8_din),
        .o_vld    (w_div_ovld),
        .i_rdy    (w_brdy[0]),
        .o_res_re (w_xx),
        .o_res_im (w_yy),
        .o_side   (w_dside)
    );

    // ------------------------------------------------------------------
    // back: shared linear unit, matrix or rotation
    // ------------------------------------------------------------------
    logic signed [16:0] w_c0x, w_c1x, w_c0y, w_c1y;
    logic signed [31:0] w_u, w_v;

    always_comb begin
        if (r_mode == MODE_MOBIUS) begin
            w_c0x = 17'(w_c);
            w_c1x = -17'(w_s);
            w_c0y = 17'(w_s);
            w_c1y = 17'(w_c);
            w_u   = w_xx;
            w_v   = w_yy;
        end else begin
            w_c0x = 17'(w_m00);
            w_c1x = 17'(w_m01);
            w_c0y = 17'(w_m10);
            w_c1y = 17'(w_m11);
            w_u   = w_dside.px;
            w_v   = w_dside.py;
        end
    end

    logic signed [48:0] r_b1_p0x, r_b1_p1x, r_b1_p0y, r_b1_p1y;
    t_side              r_b1_side;

    always_ff @(posedge i_clk) begin
        if (w_brdy[0]) begin
            r_b1_p0x  <= w_c0x * w_u;
            r_b1_p1x  <= w_c1x * w_v;
            r_b1_p0y  <= w_c0y * w_u;
            r_b1_p1y  <= w_c1y * w_v;
            r_b1_side <= w_dside;
        end
    end

    logic signed [49:0] r_b2_sx, r_b2_sy;
    t_side              r_b2_side;

    always_ff @(posedge i_clk) begin
        if (w_brdy[1]) begin
            r_b2_sx   <= 50'(r_b1_p0x) + 50'(r_b1_p1x);
            r_b2_sy   <= 50'(r_b1_p0y) + 50'(r_b1_p1y);
            r_b2_side <= r_b1_side;
        end
    end

    // Q22.28 to Q16.16, half to even (symmetric, so done on two's complement)
    function automatic logic signed [31:0] f_lin(input logic signed [49:0] s);
        logic signed [37:0] q;
        logic [11:0]        r;
        logic               inc;
        logic signed [38:0] qr;
        q   = s[49:12];
        r   = s[11:0];
        inc = (r > 12'h800) || ((r == 12'h800) && q[0]);
        qr  = 39'(q) + signed'(39'(inc));
        if (qr > 39'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (qr < -39'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return qr[31:0];
    endfunction

    logic signed [31:0] r_b3_x, r_b3_y;
    t_side              r_b3_side;

    always_ff @(posedge i_clk) begin
        if (w_brdy[2]) begin
            if (r_mode == MODE_IDENT) begin
                r_b3_x <= r_b2_side.px;
                r_b3_y <= r_b2_side.py;
            end else begin
                r_b3_x <= f_lin(r_b2_sx);
                r_b3_y <= f_lin(r_b2_sy);
            end
            r_b3_side <= r_b2_side;
        end
    end

    // viewport offset and translation
    logic signed [33:0] r_b4_ox, r_b4_oy;
    logic signed [32:0] r_b4_tx, r_b4_ty;
    t_side              r_b4_side;

    always_ff @(posedge i_clk) begin
        if (w_brdy[3]) begin
            r_b4_ox   <= 34'(r_b3_x) + 34'(r_offx);
            r_b4_oy   <= 34'(r_b3_y) + 34'(r_offy);
            r_b4_tx   <= 33'(r_b3_x) + 33'(w_tx);
            r_b4_ty   <= 33'(r_b3_y) + 33'(w_ty);
            r_b4_side <= r_b3_side;
        end
    end

    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -33'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // scale, Q34.32 product
    logic signed [65:0] r_b5_prx, r_b5_pry;
    logic signed [31:0] r_b5_shx, r_b5_shy;
    t_side              r_b5_side;

    always_ff @(posedge i_clk) begin
        if (w_brdy[4]) begin
            r_b5_prx  <= r_b4_ox * r_scx;
            r_b5_pry  <= r_b4_oy * r_scy;
            r_b5_shx  <= f_sat33(r_b4_tx);
            r_b5_shy  <= f_sat33(r_b4_ty);
            r_b5_side <= r_b4_side;
        end
    end

    // Q34.32 to integer half to even, then clamp to the pixel bound
    function automatic logic signed [15:0] f_pix(input logic signed [65:0] p);
        logic signed [33:0] q;
        logic [31:0]        r;
        logic               inc;
        logic signed [34:0] qr;
        q   = p[65:32];
        r   = p[31:0];
        inc = (r > 32'h8000_0000) || ((r == 32'h8000_0000) && q[0]);
        qr  = 35'(q) + signed'(35'(inc));
        if (qr > PB) begin
            qr = PB;
        end else if (qr < -PB) begin
            qr = -PB;
        end
        return qr[15:0];
    endfunction

    logic signed [15:0] r_b6_pix, r_b6_piy;
    logic signed [31:0] r_b6_shx, r_b6_shy;
    logic               r_b6_dz, r_b6_last;

    always_ff @(posedge i_clk) begin
        if (w_brdy[5]) begin
            if (r_b5_side.dz) begin
                r_b6_pix <= 16'(PIXEL_BOUND);
                r_b6_piy <= 16'(PIXEL_BOUND);
                r_b6_shx <= 32'sh7fff_ffff;
                r_b6_shy <= 32'sh7fff_ffff;
            end else begin
                r_b6_pix <= f_pix(r_b5_prx);
                r_b6_piy <= f_pix(r_b5_pry);
                r_b6_shx <= r_b5_shx;
                r_b6_shy <= r_b5_shy;
            end
            r_b6_dz   <= r_b5_side.dz;
            r_b6_last <= r_b5_side.last;
        end
    end

    assign o_px.valid            = r_bv[NB-1];
    assign o_px.pixel_x          = r_b6_pix;
    assign o_px.pixel_y          = r_b6_piy;
    assign o_px.shifted_x        = r_b6_shx;
    assign o_px.shifted_y        = r_b6_shy;
    assign o_px.denominator_zero = r_b6_dz;
    assign o_px.last_out         = r_b6_last;

endmodule

// ----- hdl/ptp_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, two lanes sharing one denominator, one quotient bit per stage
// depends on ptp_pkg

module ptp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  ptp_pkg::t_div_in   i_din,
    output logic               o_vld,
    input  logic               i_rdy,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output ptp_pkg::t_side     o_side
);
    import ptp_pkg::*;

    localparam int NST = DIV_STAGES;

    logic [NST-1:0]    r_vld;
    logic [NST:0]      w_rdy;
    logic [NST-1:0]    w_vin;

    logic [NUM_MW-1:0] r_rem [NST-1][2];
    logic [DIV_QW-1:0] r_q   [NST-1][2];
    logic              r_ovf [NST-1][2];
    logic              r_neg [NST-1][2];
    logic [DEN_W-1:0]  r_d   [NST-1];
    t_side             r_side [NST-1];

    logic signed [31:0] r_res [2];
    t_side              r_side_o;

    // stall chain
    always_comb begin
        w_rdy[NST] = i_rdy;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_vld[NST-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    for (genvar k = 0; k < NST - 1; k++) begin : g_st
        if (k == 0) begin : g_init
            logic w_ovf_re, w_ovf_im;
            // quotient would not fit the kept bits
            assign w_ovf_re = DIV_CW'(i_din.mag_re) >= (DIV_CW'(i_din.den) << DIV_QW);
            assign w_ovf_im = DIV_CW'(i_din.mag_im) >= (DIV_CW'(i_din.den) << DIV_QW);
            always_ff @(posedge i_clk) begin
                if (w_rdy[0]) begin
                    r_rem[0][0] <= i_din.mag_re;
                    r_rem[0][1] <= i_din.mag_im;
                    r_q[0][0]   <= '0;
                    r_q[0][1]   <= '0;
                    r_ovf[0][0] <= w_ovf_re;
                    r_ovf[0][1] <= w_ovf_im;
                    r_neg[0][0] <= i_din.neg_re;
                    r_neg[0][1] <= i_din.neg_im;
                    r_d[0]      <= i_din.den;
                    r_side[0]   <= i_din.side;
                end
            end
        end else begin : g_bit
            localparam int B = DIV_QW - k;
            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_d[k]    <= r_d[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
            for (genvar c = 0; c < 2; c++) begin : g_ch
                logic [DIV_CW-1:0] w_sub;
                logic              w_ge;
                assign w_sub = DIV_CW'(r_d[k-1]) << B;
                assign w_ge  = DIV_CW'(r_rem[k-1][c]) >= w_sub;
                always_ff @(posedge i_clk) begin
                    if (w_rdy[k]) begin
                        r_rem[k][c] <= w_ge ? NUM_MW'(DIV_CW'(r_rem[k-1][c]) - w_sub)
                                            : r_rem[k-1][c];
                        r_q[k][c]   <= r_q[k-1][c] | (DIV_QW'(w_ge) << B);
                        r_ovf[k][c] <= r_ovf[k-1][c];
                        r_neg[k][c] <= r_neg[k-1][c];
                    end
                end
            end
        end
    end

    // round half to even, saturate, apply sign
    for (genvar c = 0; c < 2; c++) begin : g_fin
        logic [NUM_MW:0] w_r2;
        logic [NUM_MW:0] w_dd;
        logic            w_inc;
        logic [31:0]     w_qr;
        logic            w_sat;
        assign w_r2  = {r_rem[NST-2][c], 1'b0};
        assign w_dd  = (NUM_MW + 1)'(r_d[NST-2]);
        assign w_inc = (w_r2 > w_dd) || ((w_r2 == w_dd) && r_q[NST-2][c][0]);
        assign w_qr  = {1'b0, r_q[NST-2][c]} + 32'(w_inc);
        assign w_sat = r_ovf[NST-2][c] || w_qr[31];
        always_ff @(posedge i_clk) begin
            if (w_rdy[NST-1]) begin
                if (w_sat) begin
                    r_res[c] <= r_neg[NST-2][c] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    r_res[c] <= r_neg[NST-2][c] ? -signed'(w_qr) : signed'(w_qr);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NST-1]) begin
            r_side_o <= r_side[NST-2];
        end
    end

    assign o_rdy    = w_rdy[0];
    assign o_vld    = r_vld[NST-1];
    assign o_res_re = r_res[0];
    assign o_res_im = r_res[1];
    assign o_side   = r_side_o;

endmodule
